// ----- hdl/assert_macros.svh -----
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication checked with reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/sld_pkg.sv -----
// constants and types for the sorted label set delta unit
package sld_pkg;
    localparam int NumPeers    = 16;
    localparam int MaxLabels   = 32;
    localparam int NumSlots    = NumPeers * 2;
    localparam int SlotW       = $clog2(NumSlots);
    localparam int PtrW        = $clog2(MaxLabels + 1);
    localparam int IdxW        = (MaxLabels > 1) ? $clog2(MaxLabels) : 1;
    localparam int MemDepth    = NumSlots * 2 * MaxLabels;
    localparam int MemAw       = $clog2(MemDepth);

    localparam logic CHG_ADD = 1'b0;
    localparam logic CHG_DEL = 1'b1;

    typedef struct packed {
        logic        change;
        logic [31:0] label;
        logic [31:0] info;
        logic        run_end;
    } sld_result_t;

    function automatic logic [MemAw-1:0] mem_addr(input logic [SlotW-1:0] slot,
                                                  input logic bank,
                                                  input logic [IdxW-1:0] idx);
        logic [MemAw:0] a;
        a = (MemAw+1)'(({slot, bank}) * MaxLabels) + (MemAw+1)'(idx);
        return a[MemAw-1:0];
    endfunction
endpackage

// ----- hdl/sld_ram.sv -----
// generic single write, single read ram with registered read
module sld_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/sorted_label_set_delta_unit.sv -----
// top level: per-peer label snapshot merge and change reporting
// Each input transfer is one snapshot element, and the slot lookup is done at the
// transfer itself. For each stored entry that the merge reads on the way, an element
// makes one registered read of the label store and one pass through the shared
// comparator. A label that matches a stored one ends its reads with the match. An
// empty slot label or a dropped element skips the merge. The final element also
// walks the remaining stored entries. Repeated generations and out of range peers
// skip the merge and the label store. A result that must move into the full output
// register waits while the sink holds off. The unit accepts the next element only
// once an element is done and its last result sits in the output register.
`include "assert_macros.svh"
module sorted_label_set_delta_unit
    import sld_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_peer,
    input  logic        s_direction,
    input  logic [31:0] s_generation,
    input  logic [31:0] s_label,
    input  logic [31:0] s_info,
    input  logic        s_snapshot_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_change,
    output logic [3:0]  m_out_peer,
    output logic        m_out_direction,
    output logic [31:0] m_out_label,
    output logic [31:0] m_out_info,
    output logic        m_run_end
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOK, ST_RD, ST_CMP, ST_EMIT_NEW, ST_TAIL_RD, ST_TAIL_CMP, ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MODE_IDLE, MODE_FIRST, MODE_SKIP, MODE_MERGE
    } mode_t;

    localparam int MemW = 64;

    state_t             state_reg;
    logic [31:0]        thr_reg;
    mode_t              mode_reg;
    logic [SlotW-1:0]   slot_reg;
    logic [PtrW-1:0]    rp_reg, wp_reg;
    logic [PtrW-1:0]    cnt_reg;
    logic               bank_reg;
    logic [31:0]        lab_reg, inf_reg;
    logic               last_reg;
    logic               pend_reg;      // a result waits to be known last or not
    sld_result_t        pend_res_reg;
    sld_result_t        out_reg;
    logic [SlotW-1:0]   out_slot_reg;
    logic               out_valid_reg;

    logic [NumSlots-1:0] known_reg, bank_sel_reg;
    logic [PtrW-1:0]     count_reg [NumSlots];
    logic [31:0]         gen_reg   [NumSlots];

    logic [MemW-1:0]    rd_data;
    logic [MemAw-1:0]   raddr, waddr;
    logic               we;

    logic out_free;
    assign out_free = !out_valid_reg || m_ready;

    assign cfg_ready = (state_reg == ST_IDLE) && !pend_reg;
    assign s_ready   = (state_reg == ST_IDLE) && !pend_reg;

    // shared comparator: old label against threshold and new label
    logic [31:0] cmp_a;
    logic        old_valid, old_lt, old_eq;
    assign cmp_a     = rd_data[63:32];
    assign old_valid = cmp_a > thr_reg;
    assign old_lt    = cmp_a < lab_reg;
    assign old_eq    = cmp_a == lab_reg;

    // held result moves into the output register this cycle
    logic out_load;
    assign out_load = pend_reg && out_free &&
                      ((state_reg == ST_CMP && old_valid && old_lt) ||
                       (state_reg == ST_EMIT_NEW) ||
                       (state_reg == ST_TAIL_CMP && old_valid) ||
                       (state_reg == ST_FINISH));

    assign raddr = mem_addr(slot_reg, bank_reg, rp_reg[IdxW-1:0]);
    assign waddr = mem_addr(slot_reg, ~bank_reg, wp_reg[IdxW-1:0]);
    assign we    = (state_reg == ST_LOOK) && (mode_reg != MODE_SKIP)
                   && (wp_reg < PtrW'(MaxLabels));

    sld_ram #(.Width(MemW), .Depth(MemDepth)) u_store (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata({lab_reg, inf_reg}),
        .raddr(raddr),
        .rdata(rd_data)
    );

    logic in_xfer;
    assign in_xfer = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            thr_reg       <= '0;
            mode_reg      <= MODE_IDLE;
            slot_reg      <= '0;
            rp_reg        <= '0;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            bank_reg      <= 1'b0;
            known_reg     <= '0;
            bank_sel_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NumSlots; i++) count_reg[i] <= '0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
                out_slot_reg  <= slot_reg;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) thr_reg <= cfg_data;
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        lab_reg  <= s_label;
                        inf_reg  <= s_info;
                        last_reg <= s_snapshot_end;
                        if (mode_reg == MODE_IDLE) begin
                            rp_reg <= '0;
                            wp_reg <= '0;
                            if ({4'b0, s_peer} >= 8'(NumPeers)) begin
                                mode_reg <= MODE_SKIP;
                            end else begin
                                slot_reg <= SlotW'({s_peer, s_direction});
                                bank_reg <= bank_sel_reg[SlotW'({s_peer, s_direction})];
                                cnt_reg  <= count_reg[SlotW'({s_peer, s_direction})];
                                if (!known_reg[SlotW'({s_peer, s_direction})])
                                    mode_reg <= MODE_FIRST;
                                else if (gen_reg[SlotW'({s_peer, s_direction})] == s_generation)
                                    mode_reg <= MODE_SKIP;
                                else
                                    mode_reg <= MODE_MERGE;
                                if (!known_reg[SlotW'({s_peer, s_direction})] ||
                                    gen_reg[SlotW'({s_peer, s_direction})] != s_generation) begin
                                    known_reg[SlotW'({s_peer, s_direction})] <= 1'b1;
                                    gen_reg[SlotW'({s_peer, s_direction})]   <= s_generation;
                                end
                            end
                        end
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (mode_reg == MODE_SKIP) begin
                        state_reg <= ST_FINISH;
                    end else if (wp_reg < PtrW'(MaxLabels)) begin
                        wp_reg <= wp_reg + 1'b1;
                        if (lab_reg > thr_reg) begin
                            if (mode_reg == MODE_MERGE && rp_reg < cnt_reg) state_reg <= ST_RD;
                            else state_reg <= ST_EMIT_NEW;
                        end else begin
                            state_reg <= ST_TAIL_RD;
                        end
                    end else begin
                        state_reg <= ST_TAIL_RD;
                    end
                end
                ST_RD: state_reg <= ST_CMP;   // registered read in flight
                ST_CMP: begin
                    if (!pend_reg || out_free) begin
                        if (!old_valid) begin
                            rp_reg    <= rp_reg + 1'b1;
                            state_reg <= (rp_reg + 1'b1 < cnt_reg) ? ST_RD : ST_EMIT_NEW;
                        end else if (old_lt) begin
                            if (pend_reg) out_reg <= pend_res_reg;
                            pend_reg     <= 1'b1;
                            pend_res_reg <= '{CHG_DEL, rd_data[63:32], rd_data[31:0], 1'b0};
                            rp_reg       <= rp_reg + 1'b1;
                            state_reg    <= (rp_reg + 1'b1 < cnt_reg) ? ST_RD : ST_EMIT_NEW;
                        end else if (old_eq) begin
                            rp_reg    <= rp_reg + 1'b1;
                            state_reg <= ST_TAIL_RD;
                        end else begin
                            state_reg <= ST_EMIT_NEW;
                        end
                    end
                end
                ST_EMIT_NEW: begin
                    if (!pend_reg || out_free) begin
                        if (pend_reg) out_reg <= pend_res_reg;
                        pend_reg     <= 1'b1;
                        pend_res_reg <= '{CHG_ADD, lab_reg, inf_reg, 1'b0};
                        state_reg    <= ST_TAIL_RD;
                    end
                end
                ST_TAIL_RD: begin
                    if (last_reg && mode_reg == MODE_MERGE && rp_reg < cnt_reg)
                        state_reg <= ST_TAIL_CMP;
                    else
                        state_reg <= ST_FINISH;
                end
                ST_TAIL_CMP: begin
                    if (!pend_reg || out_free || !old_valid) begin
                        if (old_valid) begin
                            if (pend_reg) out_reg <= pend_res_reg;
                            pend_reg     <= 1'b1;
                            pend_res_reg <= '{CHG_DEL, rd_data[63:32], rd_data[31:0], 1'b0};
                        end
                        rp_reg    <= rp_reg + 1'b1;
                        state_reg <= ST_TAIL_RD;
                    end
                end
                ST_FINISH: begin
                    // flush the held result marked as the last one of the item
                    if (!pend_reg || out_free) begin
                        if (pend_reg) begin
                            out_reg  <= '{pend_res_reg.change, pend_res_reg.label,
                                          pend_res_reg.info, 1'b1};
                            pend_reg <= 1'b0;
                        end
                        if (last_reg) begin
                            if (mode_reg == MODE_FIRST || mode_reg == MODE_MERGE) begin
                                count_reg[slot_reg]    <= wp_reg;
                                bank_sel_reg[slot_reg] <= ~bank_sel_reg[slot_reg];
                            end
                            mode_reg <= MODE_IDLE;
                            rp_reg   <= '0;
                            wp_reg   <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_change        = out_reg.change;
    assign m_out_peer      = 4'(out_slot_reg >> 1);
    assign m_out_direction = out_slot_reg[0];
    assign m_out_label     = out_reg.label;
    assign m_out_info      = out_reg.info;
    assign m_run_end       = out_reg.run_end;

    `ASSERT_CLK(a_no_accept_busy, aclk, aresetn, (state_reg != ST_IDLE) |-> !s_ready, "busy")
    `ASSERT_CLK(a_wp_bound, aclk, aresetn, wp_reg <= PtrW'(MaxLabels), "wp past list size")
    `ASSERT_CLK(a_rp_bound, aclk, aresetn, rp_reg <= cnt_reg || mode_reg != MODE_MERGE, "rp")
endmodule

// ----- verif/sorted_label_set_delta_unit_tb.sv -----
`timescale 1ns / 100ps
// testbench for the sorted label set delta unit: directed and random snapshots vs a predictor
module sorted_label_set_delta_unit_tb
    import sld_pkg::*;
();

    typedef enum logic [1:0] {
        SNAP_IDLE,
        SNAP_FIRST,
        SNAP_SKIP,
        SNAP_MERGE
    } snap_mode_t;

    typedef struct packed {
        logic        change;
        logic [3:0]  peer;
        logic        direction;
        logic [31:0] label;
        logic [31:0] info;
        logic        run_end;
    } change_t;

    localparam int CycleLimit = 600000;
    localparam int SettleCycles = 300;
    localparam int LongHold = 400;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [3:0]  s_peer;
    logic        s_direction;
    logic [31:0] s_generation;
    logic [31:0] s_label;
    logic [31:0] s_info;
    logic        s_snapshot_end;
    logic        m_valid;
    logic        m_ready;
    logic        m_change;
    logic [3:0]  m_out_peer;
    logic        m_out_direction;
    logic [31:0] m_out_label;
    logic [31:0] m_out_info;
    logic        m_run_end;

    sorted_label_set_delta_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_peer          (s_peer),
        .s_direction     (s_direction),
        .s_generation    (s_generation),
        .s_label         (s_label),
        .s_info          (s_info),
        .s_snapshot_end  (s_snapshot_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_change        (m_change),
        .m_out_peer      (m_out_peer),
        .m_out_direction (m_out_direction),
        .m_out_label     (m_out_label),
        .m_out_info      (m_out_info),
        .m_run_end       (m_run_end)
    );

    // predictor state
    logic [31:0] threshold;
    logic [31:0] label_mem [NumSlots][2][MaxLabels];
    logic [31:0] info_mem  [NumSlots][2][MaxLabels];
    int          entry_count [NumSlots];
    logic [31:0] slot_gen    [NumSlots];
    logic        slot_seen   [NumSlots];
    logic        slot_bank   [NumSlots];
    int          rd_ptr;
    int          wr_ptr;
    snap_mode_t  snap_mode;
    int          cur_slot;

    change_t pending_changes[$];
    int      error_count = 0;
    int      items_sent;
    int      changes_seen = 0;
    int      cycle_count = 0;
    logic    quiet;
    logic    hold_req;
    int      hold_left;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h (change %0d)", what, got, want,
                 changes_seen);
        error_count++;
    endtask

    function automatic change_t make_change(input logic chg, input logic [31:0] lab,
                                            input logic [31:0] inf);
        change_t c;
        c.change = chg;
        c.peer = 4'(cur_slot >> 1);
        c.direction = cur_slot[0];
        c.label = lab;
        c.info = inf;
        c.run_end = 1'b0;
        return c;
    endfunction

    // merge one accepted element against the stored list and queue its changes
    task automatic predict_element(input logic [3:0] peer, input logic dir,
                                   input logic [31:0] gen, input logic [31:0] lab,
                                   input logic [31:0] inf, input logic last);
        change_t run[$];
        logic    ob;
        logic    matched;
        logic [31:0] old;
        if (snap_mode == SNAP_IDLE) begin
            rd_ptr = 0;
            wr_ptr = 0;
            cur_slot = peer * 2 + dir;
            if (!slot_seen[cur_slot])
                snap_mode = SNAP_FIRST;
            else if (slot_gen[cur_slot] == gen)
                snap_mode = SNAP_SKIP;
            else
                snap_mode = SNAP_MERGE;
            if (snap_mode != SNAP_SKIP) begin
                slot_seen[cur_slot] = 1'b1;
                slot_gen[cur_slot] = gen;
            end
        end
        if (snap_mode == SNAP_FIRST || snap_mode == SNAP_MERGE) begin
            ob = slot_bank[cur_slot];
            if (wr_ptr < MaxLabels) begin
                label_mem[cur_slot][!ob][wr_ptr] = lab;
                info_mem[cur_slot][!ob][wr_ptr] = inf;
                wr_ptr++;
                if (lab > threshold) begin
                    matched = 1'b0;
                    if (snap_mode == SNAP_MERGE) begin
                        while (rd_ptr < entry_count[cur_slot]) begin
                            old = label_mem[cur_slot][ob][rd_ptr];
                            if (old <= threshold) begin
                                rd_ptr++;
                            end else if (old < lab) begin
                                run = {run, make_change(CHG_DEL, old,
                                                        info_mem[cur_slot][ob][rd_ptr])};
                                rd_ptr++;
                            end else begin
                                break;
                            end
                        end
                        if (rd_ptr < entry_count[cur_slot] &&
                            label_mem[cur_slot][ob][rd_ptr] == lab) begin
                            rd_ptr++;
                            matched = 1'b1;
                        end
                    end
                    if (!matched)
                        run = {run, make_change(CHG_ADD, lab, inf)};
                end
            end
            if (last) begin
                if (snap_mode == SNAP_MERGE) begin
                    while (rd_ptr < entry_count[cur_slot]) begin
                        old = label_mem[cur_slot][ob][rd_ptr];
                        if (old > threshold)
                            run = {run, make_change(CHG_DEL, old,
                                                    info_mem[cur_slot][ob][rd_ptr])};
                        rd_ptr++;
                    end
                end
                entry_count[cur_slot] = wr_ptr;
                slot_bank[cur_slot] = !ob;
            end
        end
        if (last)
            snap_mode = SNAP_IDLE;
        if (run.size() > 0)
            run[run.size()-1].run_end = 1'b1;
        pending_changes = {pending_changes, run};
    endtask

    task automatic send_element(input logic [3:0] peer, input logic dir,
                                input logic [31:0] gen, input logic [31:0] lab,
                                input logic [31:0] inf, input logic last);
        if (!quiet && $urandom_range(0, 99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_peer <= peer;
        s_direction <= dir;
        s_generation <= gen;
        s_label <= lab;
        s_info <= inf;
        s_snapshot_end <= last;
        do @(posedge aclk); while (!s_ready);
        predict_element(peer, dir, gen, lab, inf, last);
        items_sent++;
    endtask

    task automatic send_list(input logic [3:0] peer, input logic dir,
                             input logic [31:0] gen, input logic [31:0] labs[$]);
        foreach (labs[i])
            send_element(peer, dir, gen, labs[i], $urandom(), i == labs.size() - 1);
    endtask

    // one snapshot with random content; later elements carry junk routing fields
    task automatic send_snapshot(input logic [3:0] peer, input logic dir,
                                 input logic [31:0] gen, input int len,
                                 input logic full_range, input logic shuffled);
        logic [31:0] labs[$];
        logic [31:0] v;
        v = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            if (full_range) begin
                labs = {labs, 32'($urandom())};
            end else begin
                labs = {labs, v};
                v += $urandom_range(1, 5);
            end
        end
        if (shuffled)
            labs.shuffle();
        else if (full_range)
            labs.sort();
        for (int i = 0; i < len; i++) begin
            if (i == 0)
                send_element(peer, dir, gen, labs[i], $urandom(), len == 1);
            else
                send_element(4'($urandom()), 1'($urandom()), $urandom(), labs[i],
                             $urandom(), i == len - 1);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_changes.size() > 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        threshold = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        logic [31:0] labs[$];
        write_threshold(32'h0);
        // first snapshot: empty slot label skipped, everything else added
        labs = '{32'h0, 32'h5, 32'ha, 32'hffff_ffff};
        send_list(4'h0, 1'b0, 32'h0, labs);
        // repeated generation is a no-op
        labs = '{32'h1, 32'h2};
        send_list(4'h0, 1'b0, 32'h0, labs);
        // new generation: interleaved adds and removes, tail removal
        labs = '{32'h3, 32'ha, 32'h14};
        send_list(4'h0, 1'b0, 32'hffff_ffff, labs);
        // receive side of the top peer, extreme info
        send_element(4'hf, 1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
        send_element(4'h3, 1'b0, 32'h1234, 32'h8000_0000, 32'h0, 1'b1);
        // single element snapshot removing everything
        send_element(4'hf, 1'b1, 32'h1, 32'h0, 32'h0, 1'b1);
        // unsorted list
        labs = '{32'h9, 32'h2, 32'h7};
        send_list(4'h0, 1'b0, 32'h2, labs);
        wait_drained();
    endtask

    task automatic test_overlong();
        send_snapshot(4'h7, 1'b1, $urandom(), MaxLabels + 3, 1'b0, 1'b0);
        send_snapshot(4'h7, 1'b1, $urandom(), MaxLabels + 2, 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_threshold_change();
        write_threshold(32'd20);
        send_snapshot(4'h7, 1'b1, $urandom(), 12, 1'b0, 1'b0);
        send_snapshot(4'h0, 1'b0, $urandom(), 6, 1'b0, 1'b0);
        wait_drained();
        write_threshold(32'hffff_ffff);
        send_snapshot(4'h7, 1'b1, $urandom(), 5, 1'b1, 1'b0);
        wait_drained();
        write_threshold(32'h0);
    endtask

    task automatic random_phase(input int count, input int peer_hi);
        logic [3:0]  peer;
        logic        dir;
        logic [31:0] gen;
        int          len;
        int          stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            peer = 4'($urandom_range(0, peer_hi));
            dir = 1'($urandom());
            gen = ($urandom_range(0, 99) < 25) ? slot_gen[peer * 2 + dir] : $urandom();
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, MaxLabels + 4)
                                               : $urandom_range(1, 8);
            send_snapshot(peer, dir, gen, len, $urandom_range(0, 9) == 0,
                          $urandom_range(0, 9) == 0);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        random_phase(40, 3);
    endtask

    // receiver: random stalls, plus one long hold counted here
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_req) begin
            m_ready <= 1'b0;
            hold_left <= LongHold;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= quiet || $urandom_range(0, 99) >= 6;
        end
    end

    always @(posedge aclk) begin
        change_t want;
        if (aresetn && m_valid && m_ready) begin
            changes_seen++;
            if (pending_changes.size() == 0) begin
                report_mismatch("unexpected change label", m_out_label, 32'h0);
            end else begin
                want = pending_changes.pop_front();
                if (m_change !== want.change)
                    report_mismatch("change", 32'(m_change), 32'(want.change));
                if (m_out_peer !== want.peer)
                    report_mismatch("peer", 32'(m_out_peer), 32'(want.peer));
                if (m_out_direction !== want.direction)
                    report_mismatch("direction", 32'(m_out_direction), 32'(want.direction));
                if (m_out_label !== want.label)
                    report_mismatch("label", m_out_label, want.label);
                if (m_out_info !== want.info)
                    report_mismatch("info", m_out_info, want.info);
                if (m_run_end !== want.run_end)
                    report_mismatch("run_end", 32'(m_run_end), 32'(want.run_end));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_peer = '0;
        s_direction = 1'b0;
        s_generation = '0;
        s_label = '0;
        s_info = '0;
        s_snapshot_end = 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        items_sent = 0;
        threshold = '0;
        snap_mode = SNAP_IDLE;
        cur_slot = 0;
        rd_ptr = 0;
        wr_ptr = 0;
        for (int i = 0; i < NumSlots; i++) begin
            entry_count[i] = 0;
            slot_gen[i] = '0;
            slot_seen[i] = 1'b0;
            slot_bank[i] = 1'b0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_overlong();
        test_threshold_change();
        test_backpressure();
        random_phase(60, 15);
        quiet = 1'b1;
        random_phase(60, 15);
        quiet = 1'b0;
        write_threshold($urandom_range(1, 12));
        random_phase(60, 5);
        write_threshold(32'h0);
        random_phase(40, 15);

        wait_drained();
        $display("sent %0d snapshot elements, checked %0d changes", items_sent, changes_seen);
        $display("covered first, repeated and changed generations, overlong and unsorted lists,"
                 , " threshold moves and output stalls");
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", error_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
